>>> design/vn_pkg.sv
// Shared types and constants for the vector normalize pipeline.
`timescale 1ns / 1ps
package vn_pkg;
   localparam int FRAC_BITS = 30;
   localparam int QUOT_BITS = FRAC_BITS + 1;
   localparam int UNIT_BITS = 32;
   localparam int LANES     = 3;

   typedef struct packed {
      logic             valid;
      logic             zero;
      logic [LANES-1:0] neg;
   } vn_ctl_type;
endpackage

>>> design/vector3_normalize.sv
// Top level of the 3-component vector normalize pipeline.
// Usage:
//   Input channel req_: present comp_x/comp_y/comp_z with req_valid; a transfer
//   happens on a clock edge with req_valid high and req_stall low.
//   Result channel rsp_: unit_x/unit_y/unit_z (30 fraction bits, truncated toward
//   zero) and zero_length, transferred when rsp_valid is high and rsp_stall low.
//   A zero vector returns zeros with zero_length set.
// Throughput: one vector per cycle unless the output stalls. Path: two front stages
//   (squares, squared length), a chain of 31 cells that each settle one quotient
//   bit by a shift-subtract on the remainder, and the output register.
// Reset: synchronous, active high; empties every stage, no result pending.
// Stall: while rsp_stall holds a waiting result, the whole chain holds and
//   req_stall rises; the input is still taken whenever the output register is
//   empty or its result leaves in the same cycle.
`timescale 1ns / 1ps
module vector3_normalize
   import vn_pkg::*;
#(
   parameter int COMPONENT_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [COMPONENT_BITS-1:0]   req_comp_x,
   input  logic [COMPONENT_BITS-1:0]   req_comp_y,
   input  logic [COMPONENT_BITS-1:0]   req_comp_z,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [UNIT_BITS-1:0]        rsp_unit_x,
   output logic [UNIT_BITS-1:0]        rsp_unit_y,
   output logic [UNIT_BITS-1:0]        rsp_unit_z,
   output logic                        rsp_zero_length
);
   localparam int CB = COMPONENT_BITS;
   localparam int SW = 2 * CB;
   localparam int RW = 2 * CB + 64;
   localparam int NC = QUOT_BITS;

   logic                                   adv;
   logic [LANES-1:0][CB-1:0]               comp;
   vn_ctl_type                             ctl   [NC+1];
   logic [SW-1:0]                          sum   [NC+1];
   logic [LANES-1:0][RW-1:0]               rem   [NC+1];
   logic [LANES-1:0][RW-1:0]               prod  [NC+1];
   logic [LANES-1:0][QUOT_BITS-1:0]        quot  [NC+1];
   logic [LANES-1:0][UNIT_BITS-1:0]        unit_in;
   logic                                   rsp_valid_ff;
   logic [LANES-1:0][UNIT_BITS-1:0]        unit_ff;
   logic                                   zero_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign comp      = {req_comp_z, req_comp_y, req_comp_x};

   vn_front #(.CB(CB)) u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .comp     (comp),
      .ctl_out  (ctl[0]),
      .sum_out  (sum[0]),
      .rem_out  (rem[0])
   );

   assign prod[0] = '0;
   assign quot[0] = '0;

   for (genvar k = 0; k < NC; k++) begin : g_cell
      vn_cell #(.CB(CB), .BIT(FRAC_BITS - k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .ctl_in   (ctl[k]),
         .sum_in   (sum[k]),
         .rem_in   (rem[k]),
         .prod_in  (prod[k]),
         .quot_in  (quot[k]),
         .ctl_out  (ctl[k+1]),
         .sum_out  (sum[k+1]),
         .rem_out  (rem[k+1]),
         .prod_out (prod[k+1]),
         .quot_out (quot[k+1])
      );
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (ctl[NC].zero) begin
            unit_in[i] = '0;
         end else if (ctl[NC].neg[i]) begin
            unit_in[i] = UNIT_BITS'(0) - UNIT_BITS'(quot[NC][i]);
         end else begin
            unit_in[i] = UNIT_BITS'(quot[NC][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= ctl[NC].valid;
      end
      if (adv) begin
         unit_ff <= unit_in;
         zero_ff <= ctl[NC].zero;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_unit_x      = unit_ff[0];
   assign rsp_unit_y      = unit_ff[1];
   assign rsp_unit_z      = unit_ff[2];
   assign rsp_zero_length = zero_ff;
endmodule

>>> design/vn_front.sv
// Front stages: component magnitudes, squares and squared length.
`timescale 1ns / 1ps
module vn_front
   import vn_pkg::*;
#(
   parameter int CB = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            in_valid,
   input  logic [LANES-1:0][CB-1:0]        comp,
   output vn_ctl_type                      ctl_out,
   output logic [2*CB-1:0]                 sum_out,
   output logic [LANES-1:0][2*CB+63:0]     rem_out
);
   localparam int SW = 2 * CB;
   localparam int RW = 2 * CB + 64;

   logic [LANES-1:0][CB-1:0] mag;
   logic [LANES-1:0]         neg;
   logic [LANES-1:0][SW-1:0] sq_ff;
   logic [LANES-1:0]         neg_ff;
   logic                     valid_ff;
   logic [SW-1:0]            sum_in;
   vn_ctl_type               ctl_ff;
   logic [SW-1:0]            sum_ff;
   logic [LANES-1:0][RW-1:0] rem_ff;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         neg[i] = comp[i][CB-1];
         mag[i] = neg[i] ? (~comp[i] + CB'(1)) : comp[i];
      end
      sum_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         valid_ff     <= in_valid;
         ctl_ff.valid <= valid_ff;
      end
      if (adv) begin
         for (int i = 0; i < LANES; i++) begin
            sq_ff[i]  <= SW'(mag[i]) * SW'(mag[i]);
            rem_ff[i] <= RW'(sq_ff[i]) << (2 * FRAC_BITS);
         end
         neg_ff      <= neg;
         ctl_ff.neg  <= neg_ff;
         ctl_ff.zero <= (sum_in == '0);
         sum_ff      <= sum_in;
      end
   end

   assign ctl_out = ctl_ff;
   assign sum_out = sum_ff;
   assign rem_out = rem_ff;
endmodule

>>> design/vn_cell.sv
// One quotient-bit cell of the normalize chain, all three lanes.
`timescale 1ns / 1ps
module vn_cell
   import vn_pkg::*;
#(
   parameter int CB  = 16,
   parameter int BIT = 0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  vn_ctl_type                       ctl_in,
   input  logic [2*CB-1:0]                  sum_in,
   input  logic [LANES-1:0][2*CB+63:0]      rem_in,
   input  logic [LANES-1:0][2*CB+63:0]      prod_in,
   input  logic [LANES-1:0][QUOT_BITS-1:0]  quot_in,
   output vn_ctl_type                       ctl_out,
   output logic [2*CB-1:0]                  sum_out,
   output logic [LANES-1:0][2*CB+63:0]      rem_out,
   output logic [LANES-1:0][2*CB+63:0]      prod_out,
   output logic [LANES-1:0][QUOT_BITS-1:0]  quot_out
);
   localparam int SW = 2 * CB;
   localparam int RW = 2 * CB + 64;

   logic [LANES-1:0][RW-1:0]        trial;
   logic [LANES-1:0]                fits;
   logic [LANES-1:0][RW-1:0]        rem_in_v;
   logic [LANES-1:0][RW-1:0]        prod_in_v;
   logic [LANES-1:0][QUOT_BITS-1:0] quot_in_v;
   vn_ctl_type                      ctl_ff;
   logic [SW-1:0]                   sum_ff;
   logic [LANES-1:0][RW-1:0]        rem_ff;
   logic [LANES-1:0][RW-1:0]        prod_ff;
   logic [LANES-1:0][QUOT_BITS-1:0] quot_ff;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         trial[i] = (prod_in[i] << (BIT + 1)) + (RW'(sum_in) << (2 * BIT));
         fits[i]  = (rem_in[i] >= trial[i]);
         rem_in_v[i]  = fits[i] ? (rem_in[i] - trial[i]) : rem_in[i];
         prod_in_v[i] = fits[i] ? (prod_in[i] + (RW'(sum_in) << BIT)) : prod_in[i];
         quot_in_v[i] = quot_in[i] | (QUOT_BITS'(fits[i]) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl_ff.valid <= ctl_in.valid;
      end
      if (adv) begin
         ctl_ff.zero <= ctl_in.zero;
         ctl_ff.neg  <= ctl_in.neg;
         sum_ff      <= sum_in;
         rem_ff      <= rem_in_v;
         prod_ff     <= prod_in_v;
         quot_ff     <= quot_in_v;
      end
   end

   assign ctl_out  = ctl_ff;
   assign sum_out  = sum_ff;
   assign rem_out  = rem_ff;
   assign prod_out = prod_ff;
   assign quot_out = quot_ff;
endmodule
